// ===== design/assert_macros.svh =====
// assert_macros.svh
// Concurrent assertion macros for the heat stencil design files.
// Expects clk and rst_n in the scope of use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define HSG_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hsg: assertion failed");
`define HSG_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("hsg: reset assertion failed");
`else
`define HSG_ASSERT(lbl, prop)
`define HSG_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== design/hsg_pkg.sv =====
// hsg_pkg.sv
// Types and fixed constants of the heat stencil grid step block.
// No dependencies; used by the interfaces, the sequencer and the top level.
package hsg_pkg;

    localparam int VAL_W       = 16;
    localparam int ROW_OUT_W   = 4;
    localparam int COL_OUT_W   = 5;
    localparam int CS_W        = 18;
    localparam int SUM_W       = 20;
    localparam int MAG_W       = 19;
    localparam int RECIP_SHIFT = 22;
    localparam int PROD_W      = RECIP_SHIFT + VAL_W;

    localparam logic signed [VAL_W-1:0] VAL_MIN    = 16'sh8000;
    localparam logic signed [VAL_W-1:0] VAL_MAX    = 16'sh7fff;
    localparam logic [MAG_W-1:0]        RECIP_MUL  = 19'd419431;
    localparam logic [MAG_W-1:0]        ROUND_BIAS = 19'd5;

    typedef enum logic [1:0] {
        SEQ_STREAM,
        SEQ_WAIT,
        SEQ_SWEEP
    } hsg_seq_state_t;

    typedef struct packed {
        logic valid;
        logic flush;
        logic emit;
        logic interior;
        logic sel_old;
        logic last;
    } hsg_issue_t;

endpackage

// ===== design/hsg_stream_if.sv =====
// hsg_stream_if.sv
// Valid/ready channels for old cells in and new cells out.
// Depends on hsg_pkg for field widths.
interface hsg_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [hsg_pkg::VAL_W-1:0]  cell_value;
    logic                              frame_end;

    modport source (output valid, output cell_value, output frame_end, input ready);
    modport sink   (input valid, input cell_value, input frame_end, output ready);
endinterface

interface hsg_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [hsg_pkg::VAL_W-1:0]    new_value;
    logic [hsg_pkg::ROW_OUT_W-1:0]       row_index;
    logic [hsg_pkg::COL_OUT_W-1:0]       col_index;
    logic                                last_cell;
    logic signed [hsg_pkg::VAL_W-1:0]    grid_max;
    logic signed [hsg_pkg::VAL_W-1:0]    grid_min;

    modport source (output valid, output new_value, output row_index, output col_index,
                    output last_cell, output grid_max, output grid_min, input ready);
    modport sink   (input valid, input new_value, input row_index, input col_index,
                    input last_cell, input grid_max, input grid_min, output ready);
endinterface

// ===== design/hsg_seq.sv =====
// hsg_seq.sv
// Raster position counters and end-of-frame sweep sequencer: issues one line
// memory read per cycle unless stalled, for a new cell or a pending old cell.
// Depends on hsg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hsg_seq #(
    parameter int ROWS = 10,
    parameter int COLS = 20
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic                          frame_end,
    output logic                          in_ready,
    output hsg_pkg::hsg_issue_t           issue,
    output logic [$clog2(COLS)-1:0]       rd_addr,
    output logic [$clog2(ROWS)-1:0]       out_row,
    output logic [$clog2(COLS)-1:0]       out_col
);

    localparam int RW = $clog2(ROWS);
    localparam int CW = $clog2(COLS);
    localparam int LW = $clog2(COLS + 2);

    hsg_pkg::hsg_seq_state_t state_reg, state_next;

    logic [RW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] sw_row_reg;
    logic [CW-1:0] sw_col_reg;
    logic [LW-1:0] left_reg;
    logic          first_reg;

    logic accept;
    logic last_col;
    logic last_row;
    logic frame_done;
    logic row_ge1;
    logic row_ge2;
    logic col_ge1;
    logic col_ge2;
    logic sweep_step;

    assign accept     = (state_reg == hsg_pkg::SEQ_STREAM) && adv && in_valid;
    assign last_col   = (col_reg == CW'(COLS - 1));
    assign last_row   = (row_reg == RW'(ROWS - 1));
    assign frame_done = frame_end || (last_col && last_row);
    assign row_ge1    = (row_reg != '0);
    assign row_ge2    = (row_reg > RW'(1));
    assign col_ge1    = (col_reg != '0);
    assign col_ge2    = (col_reg > CW'(1));
    assign sweep_step = (state_reg == hsg_pkg::SEQ_SWEEP) && adv;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hsg_pkg::SEQ_STREAM:
            begin
                if (accept && frame_done)
                begin
                    state_next = hsg_pkg::SEQ_WAIT;
                end
            end
            hsg_pkg::SEQ_WAIT:
            begin
                if (adv)
                begin
                    state_next = hsg_pkg::SEQ_SWEEP;
                end
            end
            hsg_pkg::SEQ_SWEEP:
            begin
                if (adv && (left_reg == LW'(1)))
                begin
                    state_next = hsg_pkg::SEQ_STREAM;
                end
            end
            default:
            begin
                state_next = hsg_pkg::SEQ_STREAM;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        issue    = '0;
        rd_addr  = col_reg;
        out_row  = row_reg;
        out_col  = col_reg;
        unique case (state_reg)
            hsg_pkg::SEQ_STREAM:
            begin
                in_ready       = adv;
                issue.valid    = accept;
                issue.emit     = row_ge2 || (row_ge1 && col_ge1);
                issue.interior = row_ge2 && col_ge2;
                out_row        = col_ge1 ? (row_reg - RW'(1)) : (row_reg - RW'(2));
                out_col        = col_ge1 ? (col_reg - CW'(1)) : CW'(COLS - 1);
            end
            hsg_pkg::SEQ_SWEEP:
            begin
                issue.valid   = adv;
                issue.flush   = 1'b1;
                issue.emit    = 1'b1;
                issue.sel_old = first_reg;
                issue.last    = (left_reg == LW'(1));
                rd_addr       = sw_col_reg;
                out_row       = sw_row_reg;
                out_col       = sw_col_reg;
            end
            hsg_pkg::SEQ_WAIT:
            begin
                issue = '0;
            end
            default:
            begin
                issue = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hsg_pkg::SEQ_STREAM;
            row_reg    <= '0;
            col_reg    <= '0;
            sw_row_reg <= '0;
            sw_col_reg <= '0;
            left_reg   <= '0;
            first_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                if (frame_done)
                begin
                    row_reg <= '0;
                    col_reg <= '0;
                    // start the sweep at the oldest cell still pending
                    if (row_ge1)
                    begin
                        sw_row_reg <= row_reg - RW'(1);
                        sw_col_reg <= col_reg;
                        left_reg   <= LW'(COLS + 1);
                        first_reg  <= 1'b1;
                    end
                    else
                    begin
                        sw_row_reg <= '0;
                        sw_col_reg <= '0;
                        left_reg   <= LW'(col_reg) + LW'(1);
                        first_reg  <= 1'b0;
                    end
                end
                else if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
            if (sweep_step)
            begin
                first_reg <= 1'b0;
                left_reg  <= left_reg - LW'(1);
                if (sw_col_reg == CW'(COLS - 1))
                begin
                    sw_col_reg <= '0;
                    sw_row_reg <= sw_row_reg + RW'(1);
                end
                else
                begin
                    sw_col_reg <= sw_col_reg + CW'(1);
                end
            end
        end
    end

    `HSG_ASSERT(a_no_take_off_stream, (state_reg != hsg_pkg::SEQ_STREAM) |-> !in_ready)
    `HSG_ASSERT(a_sweep_count_range, (state_reg == hsg_pkg::SEQ_SWEEP) |-> ((left_reg != '0) && (left_reg <= LW'(COLS + 1))))
    `HSG_ASSERT(a_last_ends_sweep, (issue.valid && issue.last) |=> (state_reg == hsg_pkg::SEQ_STREAM))

endmodule

// ===== design/heat_stencil_grid_step.sv =====
// heat_stencil_grid_step.sv
// One Jacobi heat-diffusion step over a streamed grid: line memory, 3x3
// window, divide-by-ten pipeline and output register. Depends on hsg_pkg,
// hsg_stream_if, hsg_seq and assert_macros.svh.
//
//   channel   role  fields                                             transfer
//   cells     sink  cell_value, frame_end                              valid & ready
//   results   src   new_value, row_index, col_index, last_cell,
//                   grid_max, grid_min                                 valid & ready
//
// One cell is taken per cycle unless stalled; a result passes stages 1 to 5
// and the output register after the cell that completes its 3x3 neighbourhood.
// A frame-ending cell holds off the input for a wait state and then for the
// sweep of pending cells, one per cycle unless stalled, as the line memory has
// one read port. A stalled result register freezes the whole pipeline.
// Reset clears control state only; the line memory holds no reset value.
`include "assert_macros.svh"

module heat_stencil_grid_step #(
    parameter int ROWS = 10,
    parameter int COLS = 20
) (
    input  logic      clk,
    input  logic      rst_n,
    hsg_in_if.sink    cells,
    hsg_out_if.source results
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int VAL_W = hsg_pkg::VAL_W;
    localparam int CS_W  = hsg_pkg::CS_W;
    localparam int SUM_W = hsg_pkg::SUM_W;
    localparam int MAG_W = hsg_pkg::MAG_W;
    localparam int PROD_W = hsg_pkg::PROD_W;

    logic                 adv;
    hsg_pkg::hsg_issue_t  issue;
    logic [CW-1:0]        rd_addr;
    logic [RW-1:0]        iss_row;
    logic [CW-1:0]        iss_col;

    // line memory: each entry holds {previous row, row before that}
    logic [2*VAL_W-1:0]   line_mem [COLS];
    logic [2*VAL_W-1:0]   rd_reg;
    logic                 wr_en;

    // stage 1
    hsg_pkg::hsg_issue_t     s1_reg;
    logic signed [VAL_W-1:0] s1_cur_reg;
    logic [CW-1:0]           s1_wcol_reg;
    logic [RW-1:0]           s1_row_reg;
    logic [CW-1:0]           s1_col_reg;
    logic signed [VAL_W-1:0] rd_newer;
    logic signed [VAL_W-1:0] rd_older;
    logic signed [CS_W-1:0]  colsum_new;

    // window
    logic signed [CS_W-1:0]  cs_last_reg;
    logic signed [CS_W-1:0]  cs_prev_reg;
    logic signed [VAL_W-1:0] mid_last_reg;

    // stage 2
    logic                    s2_v_reg;
    logic                    s2_use_reg;
    logic                    s2_last_reg;
    logic [RW-1:0]           s2_row_reg;
    logic [CW-1:0]           s2_col_reg;
    logic signed [CS_W-1:0]  s2_ca_reg;
    logic signed [CS_W-1:0]  s2_cb_reg;
    logic signed [CS_W-1:0]  s2_cc_reg;
    logic signed [VAL_W-1:0] s2_base_reg;

    // stage 3
    logic                    s3_v_reg;
    logic                    s3_use_reg;
    logic                    s3_last_reg;
    logic [RW-1:0]           s3_row_reg;
    logic [CW-1:0]           s3_col_reg;
    logic signed [VAL_W-1:0] s3_base_reg;
    logic signed [SUM_W-1:0] s3_sum_reg;
    logic signed [SUM_W-1:0] s3_abs;

    // stage 4
    logic                    s4_v_reg;
    logic                    s4_use_reg;
    logic                    s4_last_reg;
    logic [RW-1:0]           s4_row_reg;
    logic [CW-1:0]           s4_col_reg;
    logic signed [VAL_W-1:0] s4_base_reg;
    logic                    s4_neg_reg;
    logic [MAG_W-1:0]        s4_mag_reg;

    // stage 5
    logic                    s5_v_reg;
    logic                    s5_use_reg;
    logic                    s5_last_reg;
    logic [RW-1:0]           s5_row_reg;
    logic [CW-1:0]           s5_col_reg;
    logic signed [VAL_W-1:0] s5_base_reg;
    logic                    s5_neg_reg;
    logic [PROD_W-1:0]       s5_prod_reg;
    logic [VAL_W-1:0]        quot;
    logic signed [VAL_W-1:0] stencil_val;
    logic signed [VAL_W-1:0] new_val;
    logic signed [VAL_W-1:0] max_next;
    logic signed [VAL_W-1:0] min_next;

    // output
    logic                           out_valid_reg;
    logic signed [VAL_W-1:0]        out_value_reg;
    logic [hsg_pkg::ROW_OUT_W-1:0]  out_row_reg;
    logic [hsg_pkg::COL_OUT_W-1:0]  out_col_reg;
    logic                           out_last_reg;
    logic signed [VAL_W-1:0]        out_max_reg;
    logic signed [VAL_W-1:0]        out_min_reg;
    logic signed [VAL_W-1:0]        run_max_reg;
    logic signed [VAL_W-1:0]        run_min_reg;

    assign adv = !out_valid_reg || results.ready;

    hsg_seq #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (cells.valid),
        .frame_end (cells.frame_end),
        .in_ready  (cells.ready),
        .issue     (issue),
        .rd_addr   (rd_addr),
        .out_row   (iss_row),
        .out_col   (iss_col)
    );

    assign rd_newer   = rd_reg[2*VAL_W-1:VAL_W];
    assign rd_older   = rd_reg[VAL_W-1:0];
    assign colsum_new = CS_W'(rd_older) + CS_W'(rd_newer) + CS_W'(s1_cur_reg);
    assign wr_en      = adv && s1_reg.valid && !s1_reg.flush;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg <= line_mem[rd_addr];
        end
        if (wr_en)
        begin
            line_mem[s1_wcol_reg] <= {s1_cur_reg, rd_newer};
        end
    end

    // control: valid flags and running extremes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            s4_v_reg      <= 1'b0;
            s5_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            run_max_reg   <= hsg_pkg::VAL_MIN;
            run_min_reg   <= hsg_pkg::VAL_MAX;
        end
        else if (adv)
        begin
            s1_reg        <= issue;
            s2_v_reg      <= s1_reg.valid && s1_reg.emit;
            s3_v_reg      <= s2_v_reg;
            s4_v_reg      <= s3_v_reg;
            s5_v_reg      <= s4_v_reg;
            out_valid_reg <= s5_v_reg;
            if (s5_v_reg)
            begin
                run_max_reg <= s5_last_reg ? hsg_pkg::VAL_MIN : max_next;
                run_min_reg <= s5_last_reg ? hsg_pkg::VAL_MAX : min_next;
            end
        end
    end

    // shift the 3x3 window on each new cell
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cs_prev_reg  <= cs_last_reg;
            cs_last_reg  <= colsum_new;
            mid_last_reg <= rd_newer;
        end
    end

    assign s3_abs      = s3_sum_reg[SUM_W-1] ? -s3_sum_reg : s3_sum_reg;
    assign quot        = s5_prod_reg[PROD_W-1 -: VAL_W];
    assign stencil_val = s5_neg_reg ? -quot : quot;
    assign new_val     = s5_use_reg ? stencil_val : s5_base_reg;
    assign max_next    = (new_val > run_max_reg) ? new_val : run_max_reg;
    assign min_next    = (new_val < run_min_reg) ? new_val : run_min_reg;

    // datapath payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_cur_reg  <= cells.cell_value;
            s1_wcol_reg <= rd_addr;
            s1_row_reg  <= iss_row;
            s1_col_reg  <= iss_col;

            s2_use_reg  <= s1_reg.interior && !s1_reg.flush;
            s2_last_reg <= s1_reg.last;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s2_ca_reg   <= cs_prev_reg;
            s2_cb_reg   <= cs_last_reg;
            s2_cc_reg   <= colsum_new;
            if (s1_reg.flush)
            begin
                s2_base_reg <= s1_reg.sel_old ? rd_older : rd_newer;
            end
            else
            begin
                s2_base_reg <= mid_last_reg;
            end

            s3_use_reg  <= s2_use_reg;
            s3_last_reg <= s2_last_reg;
            s3_row_reg  <= s2_row_reg;
            s3_col_reg  <= s2_col_reg;
            s3_base_reg <= s2_base_reg;
            s3_sum_reg  <= SUM_W'(s2_ca_reg) + SUM_W'(s2_cb_reg) + SUM_W'(s2_cc_reg)
                           + SUM_W'(s2_base_reg);

            s4_use_reg  <= s3_use_reg;
            s4_last_reg <= s3_last_reg;
            s4_row_reg  <= s3_row_reg;
            s4_col_reg  <= s3_col_reg;
            s4_base_reg <= s3_base_reg;
            s4_neg_reg  <= s3_sum_reg[SUM_W-1];
            s4_mag_reg  <= MAG_W'(s3_abs) + hsg_pkg::ROUND_BIAS;

            s5_use_reg  <= s4_use_reg;
            s5_last_reg <= s4_last_reg;
            s5_row_reg  <= s4_row_reg;
            s5_col_reg  <= s4_col_reg;
            s5_base_reg <= s4_base_reg;
            s5_neg_reg  <= s4_neg_reg;
            s5_prod_reg <= PROD_W'(s4_mag_reg) * PROD_W'(hsg_pkg::RECIP_MUL);

            if (s5_v_reg)
            begin
                out_value_reg <= new_val;
                out_row_reg   <= hsg_pkg::ROW_OUT_W'(s5_row_reg);
                out_col_reg   <= hsg_pkg::COL_OUT_W'(s5_col_reg);
                out_last_reg  <= s5_last_reg;
                out_max_reg   <= max_next;
                out_min_reg   <= min_next;
            end
        end
    end

    assign results.valid     = out_valid_reg;
    assign results.new_value = out_value_reg;
    assign results.row_index = out_row_reg;
    assign results.col_index = out_col_reg;
    assign results.last_cell = out_last_reg;
    assign results.grid_max  = out_max_reg;
    assign results.grid_min  = out_min_reg;

    `HSG_ASSERT(a_line_rd_wr_apart, (wr_en && issue.valid) |-> (rd_addr != s1_wcol_reg))
    `HSG_ASSERT(a_extremes_rearmed, (results.valid && results.last_cell) |-> ((run_max_reg == hsg_pkg::VAL_MIN) && (run_min_reg == hsg_pkg::VAL_MAX)))
    `HSG_ASSERT(a_final_range_order, (results.valid && results.last_cell) |-> (results.grid_max >= results.grid_min))

endmodule
